/* rtl/mhpq_pkg.sv */
// Shared constants, codes and types for the max-heap priority queue.
`default_nettype none

package mhpq_pkg;

    // Heap geometry: entries are 1-based, entry zero is never used.
    localparam int CAPACITY = 63;
    localparam int IDX_W    = 6;
    localparam int DEPTH    = 2 ** IDX_W;
    localparam int DATA_W   = 32;

    // Command codes.
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Error codes reported with every result.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // Operand choice for the shared comparator.
    typedef enum logic [1:0] {
        SEL_UP    = 2'd0,   // moving value against its parent
        SEL_CHILD = 2'd1,   // right child against left child
        SEL_DOWN  = 2'd2    // chosen child against moving value
    } cmp_sel_t;

    // Operands offered to the comparator.
    typedef struct packed {
        logic [DATA_W-1:0] move_val;
        logic [DATA_W-1:0] child_val;
        logic [DATA_W-1:0] rd_a;
        logic [DATA_W-1:0] rd_b;
    } cmp_opnd_t;

endpackage

`default_nettype wire

/* rtl/max_heap_priority_queue_core.sv */
// Top level of the max-heap priority queue: sequencer, heap memory and result register.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+---------------------------------------------------
//   input   | in_valid / in_stall  | command, push_value
//   output  | out_valid / out_stall| top_value, top_valid, element_count, error_code
//
// The time a command takes is set by the single comparator and the registered read
// ports of the heap memory: a push spends one compare state per level climbed, a pop
// a select state and a compare state per level descended.
// Reset clears the fill count, the sequencer and the result valid flag; heap contents
// are not cleared, since only entries up to the fill level are ever used.
// The input stalls whenever a command is in progress. A finished result waits in the
// result register; the next command is taken while it waits.
`default_nettype none

module max_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              command,
    input  wire logic signed [31:0] push_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [31:0]     top_value,
    output logic                   top_valid,
    output logic [5:0]             element_count,
    output logic [1:0]             error_code
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_UP_CMP  = 8'b0000_0010,
        ST_DN_LOAD = 8'b0000_0100,
        ST_DN_SEL  = 8'b0000_1000,
        ST_DN_CMP  = 8'b0001_0000,
        ST_PLACE   = 8'b0010_0000,
        ST_TOP_RD  = 8'b0100_0000,
        ST_TOP_OUT = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  count_reg;
    logic [IDX_W-1:0]  count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  cidx_reg;
    logic [IDX_W-1:0]  cidx_next;
    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic [DATA_W-1:0] cval_reg;
    logic [DATA_W-1:0] cval_next;
    logic [1:0]        err_reg;
    logic [1:0]        err_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] top_value_reg;
    logic              top_valid_reg;
    logic [IDX_W-1:0]  count_out_reg;
    logic [1:0]        err_out_reg;
    logic              out_load;

    // Heap memory: one write port, two registered read ports.
    logic [DATA_W-1:0] heap_mem [0:DEPTH-1];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    cmp_sel_t          cmp_sel;
    cmp_opnd_t         cmp_opnd;
    logic              cmp_gt;

    logic              in_xfer;
    logic [IDX_W:0]    count_w;
    logic [IDX_W:0]    left_w;
    logic [IDX_W:0]    right_w;
    logic [IDX_W:0]    cleft_w;
    logic [IDX_W-1:0]  parent;
    logic [IDX_W-1:0]  push_idx;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Index arithmetic for the tree walk.
    assign count_w  = {1'b0, count_reg};
    assign left_w   = {idx_reg, 1'b0};
    assign right_w  = left_w + (IDX_W + 1)'(1);
    assign cleft_w  = {cidx_reg, 1'b0};
    assign parent   = idx_reg >> 1;
    assign push_idx = count_reg + IDX_W'(1);

    // Shared comparator.
    assign cmp_opnd.move_val  = val_reg;
    assign cmp_opnd.child_val = cval_reg;
    assign cmp_opnd.rd_a      = rd_a_reg;
    assign cmp_opnd.rd_b      = rd_b_reg;

    mhpq_cmp u_cmp (
        .sel  (cmp_sel),
        .opnd (cmp_opnd),
        .gt   (cmp_gt)
    );

    // Memory access.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= heap_mem[raddr_a];
        rd_b_reg <= heap_mem[raddr_b];
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        cidx_next  = cidx_reg;
        val_next   = val_reg;
        cval_next  = cval_reg;
        err_next   = err_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = val_reg;
        raddr_a    = IDX_W'(1);
        raddr_b    = IDX_W'(1);
        cmp_sel    = SEL_UP;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    err_next = ERR_OK;
                    if (command == CMD_PUSH)
                    begin
                        if (count_w >= (IDX_W + 1)'(CAPACITY))
                        begin
                            err_next   = ERR_FULL;
                            state_next = ST_TOP_RD;
                        end
                        else
                        begin
                            val_next   = push_value;
                            count_next = push_idx;
                            idx_next   = push_idx;
                            raddr_a    = push_idx >> 1;
                            state_next = (push_idx == IDX_W'(1)) ? ST_PLACE : ST_UP_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            err_next   = ERR_EMPTY;
                            state_next = ST_TOP_RD;
                        end
                        else
                        begin
                            raddr_a    = count_reg;
                            count_next = count_reg - IDX_W'(1);
                            idx_next   = IDX_W'(1);
                            state_next = ST_DN_LOAD;
                        end
                    end
                end
            end
            ST_UP_CMP:
            begin
                // Parent word is in rd_a: move it down while the new value is larger.
                cmp_sel = SEL_UP;
                if (cmp_gt)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_a_reg;
                    idx_next = parent;
                    raddr_a  = parent >> 1;
                    state_next = (parent == IDX_W'(1)) ? ST_PLACE : ST_UP_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = ST_TOP_RD;
                end
            end
            ST_DN_LOAD:
            begin
                // Last element becomes the moving value at the root.
                val_next = rd_a_reg;
                raddr_a  = left_w[IDX_W-1:0];
                raddr_b  = right_w[IDX_W-1:0];
                state_next = (left_w > count_w) ? ST_PLACE : ST_DN_SEL;
            end
            ST_DN_SEL:
            begin
                // Pick the larger child, left wins ties or when the right is absent.
                cmp_sel = SEL_CHILD;
                if ((right_w <= count_w) && cmp_gt)
                begin
                    cval_next = rd_b_reg;
                    cidx_next = right_w[IDX_W-1:0];
                end
                else
                begin
                    cval_next = rd_a_reg;
                    cidx_next = left_w[IDX_W-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                // Lift the child while it is strictly larger than the moving value.
                cmp_sel = SEL_DOWN;
                wr_en   = 1'b1;
                if (cmp_gt)
                begin
                    wr_data  = cval_reg;
                    idx_next = cidx_reg;
                    raddr_a  = cleft_w[IDX_W-1:0];
                    raddr_b  = cleft_w[IDX_W-1:0] + IDX_W'(1);
                    state_next = (cleft_w > count_w) ? ST_PLACE : ST_DN_SEL;
                end
                else
                begin
                    state_next = ST_TOP_RD;
                end
            end
            ST_PLACE:
            begin
                wr_en      = 1'b1;
                state_next = ST_TOP_RD;
            end
            ST_TOP_RD:
            begin
                state_next = ST_TOP_OUT;
            end
            ST_TOP_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid: set on load, cleared by a completed transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        cidx_reg <= cidx_next;
        val_reg  <= val_next;
        cval_reg <= cval_next;
        err_reg  <= err_next;
        if (out_load)
        begin
            top_valid_reg <= (count_reg != '0);
            top_value_reg <= (count_reg != '0) ? rd_a_reg : '0;
            count_out_reg <= count_reg;
            err_out_reg   <= err_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign top_value     = top_value_reg;
    assign top_valid     = top_valid_reg;
    assign element_count = count_out_reg;
    assign error_code    = err_out_reg;

    // The fill level never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_w <= (IDX_W + 1)'(CAPACITY))
        else $error("fill count above capacity");

    // The unused entry zero is never written.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != '0))
        else $error("write to heap entry zero");

    // A push on a full heap leaves the fill level alone.
    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (command == CMD_PUSH) && (count_w == (IDX_W + 1)'(CAPACITY)))
        |=> (count_reg == $past(count_reg)))
        else $error("rejected push changed the fill count");

    // A new result appears only from the result state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_TOP_OUT))
        else $error("result raised outside the result state");

    // A pending result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* rtl/mhpq_cmp.sv */
// Shared signed greater-than unit with operand selection.
`default_nettype none

module mhpq_cmp
    import mhpq_pkg::*;
(
    input  cmp_sel_t  sel,
    input  cmp_opnd_t opnd,
    output logic      gt
);

    logic [DATA_W-1:0] cmp_a;
    logic [DATA_W-1:0] cmp_b;

    // Pick the pair of words for this step of the sift.
    always_comb
    begin
        unique case (sel)
            SEL_UP:
            begin
                cmp_a = opnd.move_val;
                cmp_b = opnd.rd_a;
            end
            SEL_CHILD:
            begin
                cmp_a = opnd.rd_b;
                cmp_b = opnd.rd_a;
            end
            SEL_DOWN:
            begin
                cmp_a = opnd.child_val;
                cmp_b = opnd.move_val;
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    // Two's complement strict compare.
    assign gt = $signed(cmp_a) > $signed(cmp_b);

endmodule

`default_nettype wire
